// File: src/ipq_pkg.sv
// Shared types and constants for the instruction prefetch queue.
// Used by every module of the block; it depends on nothing else.
package ipq_pkg;

	// Command codes carried in the command field of a transaction.
	localparam logic [2:0] CMD_STATUS     = 3'd0;
	localparam logic [2:0] CMD_PUSH_BYTE  = 3'd1;
	localparam logic [2:0] CMD_PUSH_WORD  = 3'd2;
	localparam logic [2:0] CMD_POP        = 3'd3;
	localparam logic [2:0] CMD_PRELOAD    = 3'd4;
	localparam logic [2:0] CMD_TAKE       = 3'd5;
	localparam logic [2:0] CMD_FLUSH      = 3'd6;

	// Delay kinds reported after a push or a pop.
	localparam logic [1:0] DLY_NONE  = 2'd0;
	localparam logic [1:0] DLY_WRITE = 2'd1;
	localparam logic [1:0] DLY_READ  = 2'd2;

	// Error codes.
	localparam logic [1:0] ERR_OK            = 2'd0;
	localparam logic [1:0] ERR_OVERRUN       = 2'd1;
	localparam logic [1:0] ERR_UNDERRUN      = 2'd2;
	localparam logic [1:0] ERR_EMPTY_PRELOAD = 2'd3;

	// Fill level at which a push or pop starts a bus delay.
	localparam logic [2:0] DELAY_LEVEL = 3'd3;
	// Value returned by a pop from an empty queue.
	localparam logic [7:0] UNDERRUN_BYTE = 8'hff;
	// Queue size after reset (full-width bus part).
	localparam logic [2:0] SIZE_RESET = 3'd6;

	typedef struct packed {
		logic [2:0]  command;
		logic [15:0] data_word;
	} cmd_t;

	typedef struct packed {
		logic [7:0] popped_byte;
		logic       preload_valid;
		logic [7:0] preload_byte;
		logic [2:0] fill_count;
		logic       has_room;
		logic [1:0] delay_kind;
		logic [1:0] error_code;
	} rsp_t;

endpackage

// File: src/ipq_core.sv
// Queue state of the prefetch queue: byte ring, pointers, count, preload latch, delay.
// Computes one command's result and next state combinationally. Depends on ipq_pkg.
module ipq_core #(
	parameter int MAX_DEPTH = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  ipq_pkg::cmd_t item,
	input  logic [2:0]    queue_size,
	output ipq_pkg::rsp_t result
);

	localparam int         PTR_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam logic [4:0] MAX_D = 5'(MAX_DEPTH);

	logic [7:0]       ring_q [MAX_DEPTH];
	logic [PTR_W-1:0] rp_q, wp_q, rp_d, wp_d;
	logic [2:0]       cnt_q, cnt_d;
	logic [7:0]       latch_q, latch_d;
	logic             full_q, full_d;
	logic [1:0]       dly_q, dly_d;

	logic             we0, we1, clr;
	logic [PTR_W-1:0] wa0, wa1;
	logic [7:0]       wd0, wd1;
	logic [7:0]       popped;
	logic [1:0]       err;
	logic [2:0]       eff;
	logic [2:0]       cnt_inc1, cnt_inc2, cnt_dec;

	// Pointers step by one and wrap at the usable size.
	function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
		input logic [2:0] size);
		logic [4:0] n;
		n = 5'(p) + 5'd1;
		if (n >= {2'b00, size} || n >= MAX_D)
			return '0;
		return n[PTR_W-1:0];
	endfunction

	assign eff      = ({2'b00, queue_size} > MAX_D) ? MAX_D[2:0] : queue_size;
	assign cnt_inc1 = cnt_q + 3'd1;
	assign cnt_inc2 = cnt_q + 3'd2;
	assign cnt_dec  = cnt_q - 3'd1;

	always_comb begin
		rp_d    = rp_q;
		wp_d    = wp_q;
		cnt_d   = cnt_q;
		latch_d = latch_q;
		full_d  = full_q;
		dly_d   = dly_q;
		we0     = 1'b0;
		we1     = 1'b0;
		clr     = 1'b0;
		wa0     = wp_q;
		wa1     = adv(wp_q, eff);
		wd0     = item.data_word[7:0];
		wd1     = item.data_word[15:8];
		popped  = 8'd0;
		err     = ipq_pkg::ERR_OK;
		unique case (item.command)
			ipq_pkg::CMD_PUSH_BYTE: begin
				if (cnt_q < eff) begin
					we0   = 1'b1;
					wp_d  = adv(wp_q, eff);
					cnt_d = cnt_inc1;
					dly_d = (cnt_inc1 == ipq_pkg::DELAY_LEVEL) ?
						ipq_pkg::DLY_WRITE : ipq_pkg::DLY_NONE;
				end else begin
					err = ipq_pkg::ERR_OVERRUN;
				end
			end
			ipq_pkg::CMD_PUSH_WORD: begin
				if (cnt_q < eff) begin
					// The low byte goes in even when the high byte overruns.
					we0   = 1'b1;
					wp_d  = adv(wp_q, eff);
					cnt_d = cnt_inc1;
					dly_d = (cnt_inc1 == ipq_pkg::DELAY_LEVEL) ?
						ipq_pkg::DLY_WRITE : ipq_pkg::DLY_NONE;
					if (cnt_inc1 < eff) begin
						we1   = 1'b1;
						wp_d  = adv(wa1, eff);
						cnt_d = cnt_inc2;
						dly_d = (cnt_inc2 == ipq_pkg::DELAY_LEVEL) ?
							ipq_pkg::DLY_WRITE : ipq_pkg::DLY_NONE;
					end else begin
						err = ipq_pkg::ERR_OVERRUN;
					end
				end else begin
					err = ipq_pkg::ERR_OVERRUN;
				end
			end
			ipq_pkg::CMD_POP: begin
				if (cnt_q != 3'd0) begin
					popped = ring_q[rp_q];
					rp_d   = adv(rp_q, eff);
					cnt_d  = cnt_dec;
					dly_d  = (cnt_dec >= ipq_pkg::DELAY_LEVEL) ?
						ipq_pkg::DLY_READ : ipq_pkg::DLY_NONE;
				end else begin
					popped = ipq_pkg::UNDERRUN_BYTE;
					err    = ipq_pkg::ERR_UNDERRUN;
				end
			end
			ipq_pkg::CMD_PRELOAD: begin
				if (cnt_q != 3'd0) begin
					latch_d = ring_q[rp_q];
					full_d  = 1'b1;
					rp_d    = adv(rp_q, eff);
					cnt_d   = cnt_dec;
					dly_d   = (cnt_dec >= ipq_pkg::DELAY_LEVEL) ?
						ipq_pkg::DLY_READ : ipq_pkg::DLY_NONE;
				end else begin
					err = ipq_pkg::ERR_EMPTY_PRELOAD;
				end
			end
			ipq_pkg::CMD_TAKE: begin
				latch_d = 8'd0;
				full_d  = 1'b0;
			end
			ipq_pkg::CMD_FLUSH: begin
				clr     = 1'b1;
				rp_d    = '0;
				wp_d    = '0;
				cnt_d   = 3'd0;
				latch_d = 8'd0;
				full_d  = 1'b0;
				dly_d   = ipq_pkg::DLY_NONE;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		result.popped_byte = popped;
		// A take reports the latch as it was before clearing it.
		if (item.command == ipq_pkg::CMD_TAKE) begin
			result.preload_valid = full_q;
			result.preload_byte  = latch_q;
		end else begin
			result.preload_valid = full_d;
			result.preload_byte  = latch_d;
		end
		result.fill_count = cnt_d;
		result.has_room   = (cnt_d != eff);
		result.delay_kind = dly_d;
		result.error_code = err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q    <= '0;
			wp_q    <= '0;
			cnt_q   <= 3'd0;
			latch_q <= 8'd0;
			full_q  <= 1'b0;
			dly_q   <= ipq_pkg::DLY_NONE;
		end else if (go) begin
			rp_q    <= rp_d;
			wp_q    <= wp_d;
			cnt_q   <= cnt_d;
			latch_q <= latch_d;
			full_q  <= full_d;
			dly_q   <= dly_d;
		end
	end

	// The ring itself has no reset; a flush zeroes every entry.
	always_ff @(posedge clk) begin
		if (go) begin
			if (clr) begin
				for (int i = 0; i < MAX_DEPTH; i++)
					ring_q[i] <= 8'd0;
			end else begin
				if (we0)
					ring_q[wa0] <= wd0;
				if (we1)
					ring_q[wa1] <= wd1;
			end
		end
	end

endmodule

// File: src/instruction_prefetch_queue.sv
// Instruction prefetch queue, top level: input register, queue core, result register.
// A command accepted into the input register has its result computed by the queue core and
// loaded into the result register, where it is held while the result side stalls.
// Throughput: one command per cycle unless results stall; the queue core is combinational.
// Reset (arst_n low) empties the queue, clears the preload latch and delay, sets size 6.
// Depends on ipq_pkg and ipq_core.
module instruction_prefetch_queue #(
	parameter int MAX_DEPTH = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  ipq_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ipq_pkg::rsp_t rsp,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_wdata
);

	// Stage 1 holds an accepted command transaction; stage 2 is the result register.
	logic          valid_s1;
	ipq_pkg::cmd_t cmd_s1;
	logic          valid_s2;
	ipq_pkg::rsp_t rsp_s2;
	logic [2:0]    queue_size_q;

	ipq_pkg::rsp_t core_rsp;
	logic          out_free;
	logic          go;

	// The result register can load when it is empty or being taken this cycle.
	assign out_free  = !valid_s2 || !rsp_stall;
	// The queue state advances exactly when a command moves into the result register,
	// so commands update the queue strictly in the order they were accepted.
	assign go        = valid_s1 && out_free;
	assign cmd_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall)
			cmd_s1 <= cmd;
	end

	// The user writes the size register only while no command is in flight; not enforced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_size_q <= ipq_pkg::SIZE_RESET;
		end else if (cfg_we) begin
			queue_size_q <= cfg_wdata;
		end
	end

	ipq_core #(
		.MAX_DEPTH(MAX_DEPTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.item      (cmd_s1),
		.queue_size(queue_size_q),
		.result    (core_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go)
			rsp_s2 <= core_rsp;
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

endmodule

// File: src/ipq_checker.sv
// Port-level checks for the instruction prefetch queue, bound to its top level.
// Depends on ipq_pkg and on instruction_prefetch_queue.
module ipq_checker #(
	parameter int MAX_DEPTH = 6
) (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input ipq_pkg::rsp_t rsp
);

	localparam logic [4:0] MAX_D = 5'(MAX_DEPTH);

	// A stalled result holds until it is taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// A write delay is only ever set with exactly three bytes queued.
	a_write_delay: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.delay_kind == ipq_pkg::DLY_WRITE |->
		rsp.fill_count == ipq_pkg::DELAY_LEVEL)
		else $error("write delay without three bytes queued");

	// A read delay is only ever set with three or more bytes queued.
	a_read_delay: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.delay_kind == ipq_pkg::DLY_READ |->
		rsp.fill_count >= ipq_pkg::DELAY_LEVEL)
		else $error("read delay below three bytes queued");

	// Underrun and empty preload leave an empty queue; underrun returns all ones.
	a_empty_errors: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.error_code == ipq_pkg::ERR_UNDERRUN ||
		rsp.error_code == ipq_pkg::ERR_EMPTY_PRELOAD) |->
		rsp.fill_count == 3'd0 && (rsp.error_code != ipq_pkg::ERR_UNDERRUN ||
		rsp.popped_byte == ipq_pkg::UNDERRUN_BYTE))
		else $error("empty-queue error with bytes queued or bad pop byte");

	// The count never exceeds the ring depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> {2'b00, rsp.fill_count} <= MAX_D)
		else $error("fill count beyond ring depth");

endmodule

bind instruction_prefetch_queue ipq_checker #(
	.MAX_DEPTH(MAX_DEPTH)
) u_ipq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);

// File: tb/sv/ipq_checker.sv
// Scoreboard for the instruction prefetch queue: watches the command, result and size ports,
// keeps its own image of the queue, and compares every result with its prediction.
// Depends on ipq_pkg.
`timescale 1ns / 1ps

module ipq_scoreboard #(
	parameter int MAX_DEPTH = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  logic          cmd_stall,
	input  ipq_pkg::cmd_t cmd,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  ipq_pkg::rsp_t rsp,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_wdata,
	output int            mismatches,
	output int            outstanding
);

	// Image of the queue as the block should hold it.
	logic [7:0]  ring_img [MAX_DEPTH];
	int unsigned rd_ptr;
	int unsigned wr_ptr;
	int unsigned held;
	logic [7:0]  latch_byte;
	logic        latch_set;
	logic [1:0]  delay_now;
	logic [2:0]  size_reg;

	ipq_pkg::rsp_t predicted_rsp_q [$];
	int            fail_count = 0;

	function automatic int unsigned usable_depth();
		return (size_reg > MAX_DEPTH) ? MAX_DEPTH : size_reg;
	endfunction

	// Pointers wrap at the size in force now, so a size change can strand queued bytes.
	function automatic int unsigned next_slot(int unsigned p);
		int unsigned n;
		n = p + 1;
		return (n >= usable_depth() || n >= MAX_DEPTH) ? 0 : n;
	endfunction

	function automatic void clear_ring();
		for (int i = 0; i < MAX_DEPTH; i++) begin
			ring_img[i] = '0;
		end
		rd_ptr = 0;
		wr_ptr = 0;
		held = 0;
		latch_byte = '0;
		latch_set = 1'b0;
		delay_now = ipq_pkg::DLY_NONE;
	endfunction

	function automatic bit push_byte(logic [7:0] b);
		if (held >= usable_depth()) begin
			return 1'b0;
		end
		ring_img[wr_ptr % MAX_DEPTH] = b;
		wr_ptr = next_slot(wr_ptr);
		held++;
		delay_now = (held == ipq_pkg::DELAY_LEVEL) ? ipq_pkg::DLY_WRITE : ipq_pkg::DLY_NONE;
		return 1'b1;
	endfunction

	function automatic bit pop_byte(output logic [7:0] b);
		b = '0;
		if (held == 0) begin
			return 1'b0;
		end
		b = ring_img[rd_ptr % MAX_DEPTH];
		rd_ptr = next_slot(rd_ptr);
		held--;
		delay_now = (held >= ipq_pkg::DELAY_LEVEL) ? ipq_pkg::DLY_READ : ipq_pkg::DLY_NONE;
		return 1'b1;
	endfunction

	// Applies one command to the image and returns the result it should produce.
	function automatic ipq_pkg::rsp_t predict_queue_step(ipq_pkg::cmd_t c);
		ipq_pkg::rsp_t r;
		logic [7:0]    b;
		logic          shown_valid;
		logic [7:0]    shown_byte;
		r = '0;
		r.error_code = ipq_pkg::ERR_OK;
		shown_valid = latch_set;
		shown_byte = latch_byte;
		case (c.command)
			ipq_pkg::CMD_PUSH_BYTE: begin
				if (!push_byte(c.data_word[7:0])) r.error_code = ipq_pkg::ERR_OVERRUN;
			end
			ipq_pkg::CMD_PUSH_WORD: begin
				// The low byte stays queued when only the high byte fails.
				if (!push_byte(c.data_word[7:0])) r.error_code = ipq_pkg::ERR_OVERRUN;
				else if (!push_byte(c.data_word[15:8])) r.error_code = ipq_pkg::ERR_OVERRUN;
			end
			ipq_pkg::CMD_POP: begin
				if (pop_byte(b)) begin
					r.popped_byte = b;
				end else begin
					r.popped_byte = ipq_pkg::UNDERRUN_BYTE;
					r.error_code = ipq_pkg::ERR_UNDERRUN;
				end
			end
			ipq_pkg::CMD_PRELOAD: begin
				if (pop_byte(b)) begin
					latch_byte = b;
					latch_set = 1'b1;
				end else begin
					r.error_code = ipq_pkg::ERR_EMPTY_PRELOAD;
				end
			end
			ipq_pkg::CMD_TAKE: begin
				latch_byte = '0;
				latch_set = 1'b0;
			end
			ipq_pkg::CMD_FLUSH: begin
				clear_ring();
			end
			default: begin
			end
		endcase
		// A take reports the latch as it was before clearing it.
		if (c.command != ipq_pkg::CMD_TAKE) begin
			shown_valid = latch_set;
			shown_byte = latch_byte;
		end
		r.preload_valid = shown_valid;
		r.preload_byte = shown_byte;
		r.fill_count = held[2:0];
		r.has_room = (held != usable_depth());
		r.delay_kind = delay_now;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		ipq_pkg::rsp_t want;
		if (!arst_n) begin
			clear_ring();
			size_reg = ipq_pkg::SIZE_RESET;
			predicted_rsp_q.delete();
		end else begin
			if (cfg_we) size_reg = cfg_wdata;
			if (cmd_valid && !cmd_stall) predicted_rsp_q.push_back(predict_queue_step(cmd));
			if (rsp_valid && !rsp_stall) begin
				if (predicted_rsp_q.size() == 0) begin
					$error("result transaction arrived with no prediction waiting");
					fail_count++;
				end else begin
					want = predicted_rsp_q.pop_front();
					check_field("popped_byte", want.popped_byte, rsp.popped_byte);
					check_field("preload_valid", 8'(want.preload_valid),
						8'(rsp.preload_valid));
					check_field("preload_byte", want.preload_byte, rsp.preload_byte);
					check_field("fill_count", 8'(want.fill_count), 8'(rsp.fill_count));
					check_field("has_room", 8'(want.has_room), 8'(rsp.has_room));
					check_field("delay_kind", 8'(want.delay_kind), 8'(rsp.delay_kind));
					check_field("error_code", 8'(want.error_code), 8'(rsp.error_code));
				end
			end
		end
		outstanding <= predicted_rsp_q.size();
		mismatches <= fail_count;
	end

endmodule

// File: tb/sv/tb_instruction_prefetch_queue.sv
// Top of the prefetch queue testbench: clock, reset, command stimulus, result back-pressure,
// queue-size writes and the verdict.
// Depends on ipq_pkg, instruction_prefetch_queue and ipq_scoreboard.
`timescale 1ns / 1ps

module tb_instruction_prefetch_queue;

	localparam int MAX_DEPTH = 6;
	// Command code 7 is not assigned; the block must treat it as a status read.
	localparam logic [2:0] CMD_UNUSED = 3'd7;
	localparam int PHASES = 9;
	localparam int PHASE_ITEMS = 210;
	// Roughly 1900 transactions, each at worst behind a sender gap and several result
	// stalls, stays far below this.
	localparam int CYCLE_LIMIT = 400000;

	// Every input starts at a known value; reset is held from time zero.
	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          cmd_valid = 1'b0;
	logic          cmd_stall;
	ipq_pkg::cmd_t cmd = '0;
	logic          rsp_valid;
	logic          rsp_stall = 1'b0;
	ipq_pkg::rsp_t rsp;
	logic          cfg_we = 1'b0;
	logic [2:0]    cfg_wdata = '0;

	int            mismatches;
	int            outstanding;
	int            cycle_count = 0;

	// Sender gap probability in percent, and whether the result side may stall.
	int unsigned   gap_pct = 0;
	logic          stall_on = 1'b0;
	int unsigned   stall_left = 0;

	// Queue sizes for the random phases. All eight codes appear: zero, where every
	// push overruns, seven, which acts as the full six, and both extremes of the
	// legal range. Phases follow one another without a flush, so the size often
	// changes while bytes are still queued.
	logic [2:0]    size_plan [PHASES] = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd6, 3'd3, 3'd5, 3'd2, 3'd6};

	always #5 clk = ~clk;

	instruction_prefetch_queue #(
		.MAX_DEPTH(MAX_DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	ipq_scoreboard #(
		.MAX_DEPTH(MAX_DEPTH)
	) scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Result back-pressure comes in random bursts. A burst in progress always runs out,
	// even after stalling has been switched off for the phase.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			rsp_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (stall_on && $urandom_range(0, 9) == 0) begin
			rsp_stall <= 1'b1;
			stall_left <= $urandom_range(0, 10);
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Presents one command transaction and returns at the edge that accepts it.
	// Valid stays high into the next call unless a gap is drawn, so back-to-back
	// transactions never see valid dropped and raised in the same step.
	task automatic issue(input logic [2:0] op, input logic [15:0] word);
		ipq_pkg::cmd_t item;
		int unsigned   idle;
		if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
			idle = $urandom_range(1, 11);
			cmd_valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		item.command = op;
		item.data_word = word;
		cmd <= item;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
	endtask

	// Stops sending and waits until every predicted result has been received.
	// The first edge is taken before looking, because the count from the
	// scoreboard lags the edge that accepted the last transaction.
	task automatic wait_for_replies();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Size writes are only made while the queue has nothing in flight.
	task automatic write_size(input logic [2:0] size);
		cfg_we <= 1'b1;
		cfg_wdata <= size;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Picks a command, leaning toward pushes or toward pops so that the queue
	// swings between empty and full instead of hovering in the middle.
	function automatic logic [2:0] random_command(input logic fill_heavy);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 3) return ipq_pkg::CMD_FLUSH;
		if (roll < 6) return CMD_UNUSED;
		if (roll < 12) return ipq_pkg::CMD_STATUS;
		if (roll < 20) return ipq_pkg::CMD_TAKE;
		if (fill_heavy) begin
			if (roll < 45) return ipq_pkg::CMD_PUSH_BYTE;
			if (roll < 70) return ipq_pkg::CMD_PUSH_WORD;
			if (roll < 88) return ipq_pkg::CMD_POP;
			return ipq_pkg::CMD_PRELOAD;
		end
		if (roll < 36) return ipq_pkg::CMD_PUSH_BYTE;
		if (roll < 50) return ipq_pkg::CMD_PUSH_WORD;
		if (roll < 78) return ipq_pkg::CMD_POP;
		return ipq_pkg::CMD_PRELOAD;
	endfunction

	// Hand-picked sequence at the reset size of six. It fills the whole ring early,
	// so no later pop can land on a slot that was never written, whatever sizes follow.
	task automatic run_directed();
		issue(ipq_pkg::CMD_STATUS, 16'h0000);       // empty queue, room available
		issue(ipq_pkg::CMD_POP, 16'hffff);          // underrun returns the fill byte
		issue(ipq_pkg::CMD_PRELOAD, 16'h0000);      // preload from an empty queue
		issue(ipq_pkg::CMD_TAKE, 16'hffff);         // take with nothing latched
		issue(ipq_pkg::CMD_PUSH_BYTE, 16'hff00);    // only the low byte is queued
		issue(ipq_pkg::CMD_PUSH_WORD, 16'hffff);    // reaches three bytes: write delay
		issue(ipq_pkg::CMD_PUSH_WORD, 16'h0000);
		issue(ipq_pkg::CMD_PUSH_BYTE, 16'h00ff);    // queue now full, no room
		issue(ipq_pkg::CMD_PUSH_BYTE, 16'h5aa5);    // overrun on a byte push
		issue(ipq_pkg::CMD_PUSH_WORD, 16'h1234);    // overrun on both bytes of a word
		issue(ipq_pkg::CMD_POP, 16'h0000);          // five left: read delay
		issue(ipq_pkg::CMD_PRELOAD, 16'hffff);      // four left, byte lands in the latch
		issue(ipq_pkg::CMD_STATUS, 16'hffff);
		issue(ipq_pkg::CMD_TAKE, 16'h0000);         // reports the latch before clearing it
		issue(ipq_pkg::CMD_TAKE, 16'h0000);
		issue(ipq_pkg::CMD_POP, 16'hffff);          // three left: still a read delay
		issue(ipq_pkg::CMD_POP, 16'h0000);          // two left: no delay
		issue(ipq_pkg::CMD_PUSH_WORD, 16'hc33c);
		issue(ipq_pkg::CMD_PUSH_BYTE, 16'h0080);
		issue(ipq_pkg::CMD_PUSH_WORD, 16'h7f01);    // low byte fills the queue, high overruns
		issue(ipq_pkg::CMD_PRELOAD, 16'h0000);
		issue(CMD_UNUSED, 16'hffff);                // unassigned code behaves as status
		issue(ipq_pkg::CMD_FLUSH, 16'hffff);        // empties queue and latch, size is kept
		issue(ipq_pkg::CMD_STATUS, 16'h0000);
	endtask

	initial begin
		logic fill_heavy;
		logic last_phase;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		stall_on <= 1'b1;
		run_directed();

		for (int ph = 0; ph < PHASES; ph++) begin
			// Draining here also makes the sender wait until every result is back.
			wait_for_replies();
			write_size(size_plan[ph]);

			// Each phase draws its own idling mix; some run with none at all, and the
			// closing phase has no gaps and starts no new stall bursts.
			last_phase = (ph == PHASES - 1);
			case ($urandom_range(0, 2))
				0: gap_pct = 0;
				1: gap_pct = 8;
				default: gap_pct = 25;
			endcase
			if (last_phase) gap_pct = 0;
			stall_on <= !last_phase && ($urandom_range(0, 2) != 0);

			fill_heavy = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 35 == 0) fill_heavy = $urandom_range(0, 1);
				issue(random_command(fill_heavy), 16'($urandom_range(0, 16'hffff)));
			end
		end

		wait_for_replies();
		// Wait on, so that a stray extra result would still be caught.
		repeat (8) @(posedge clk);

		if (mismatches == 0 && outstanding == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// File: sim.f
src/ipq_pkg.sv
src/ipq_core.sv
src/instruction_prefetch_queue.sv
src/ipq_checker.sv
tb/sv/ipq_checker.sv
tb/sv/tb_instruction_prefetch_queue.sv
